// File: sv/cimt_pkg.sv
package cimt_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [2:0] status_t;

  localparam cmd_t CMD_RX    = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;
  localparam cmd_t CMD_RSVD  = 2'd3;

  localparam status_t ST_UPDATED  = 3'd0;
  localparam status_t ST_INSERTED = 3'd1;
  localparam status_t ST_DROPPED  = 3'd2;
  localparam status_t ST_READ_OK  = 3'd3;
  localparam status_t ST_BAD_IDX  = 3'd4;
  localparam status_t ST_CLEARED  = 3'd5;

  typedef struct packed {
    cmd_t        cmd;
    logic [28:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic [7:0]  read_index;
  } cimt_in_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  entry_index;
    logic [28:0] entry_id;
    logic [3:0]  entry_len;
    logic [63:0] entry_data;
    logic [31:0] entry_count;
    logic [7:0]  fill_level;
    logic [31:0] total_frames;
  } cimt_out_t;

  typedef struct packed {
    logic [28:0] id;
    logic [3:0]  len;
    logic [63:0] data;
    logic [31:0] count;
  } cimt_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_DONE
  } cimt_state_e;

endpackage

// File: sv/can_id_message_table.sv
// channel   direction  handshake              payload
// in        input      in_valid_i / in_stall_o   in_i  (cimt_in_t)
// out       output     out_valid_o / out_stall_i out_o (cimt_out_t)
//
// a received frame scans the table one entry per cycle through the single read
// port, until a hit or the end of the filled entries
// a clear or a bad-index read skips S_READ; the input stalls while an item is at work
// rst_ni clears fill level, frame total and handshake state; the table is not wiped
// a finished result waits in a holding register while the output is stalled
module can_id_message_table
  import cimt_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  cimt_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output cimt_out_t out_o
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [7:0] FillMax = 8'(TABLE_DEPTH);

  cimt_state_e state_q, state_d;
  logic [7:0]  fill_q, fill_d;
  logic [31:0] total_q, total_d;
  logic [7:0]  scan_q, scan_d;
  logic        chk_q, chk_d;
  logic [7:0]  chk_idx_q, chk_idx_d;
  logic        out_valid_q, out_valid_d;
  cimt_in_t    in_q, in_d;
  cimt_out_t   res_q, res_d;
  cimt_out_t   out_q, out_d;

  cimt_entry_t mem [TABLE_DEPTH];
  cimt_entry_t rdata_q;
  cimt_entry_t wdata;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [IdxW-1:0] raddr;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      total_q     <= '0;
      scan_q      <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      scan_q      <= scan_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    res_q     <= res_d;
    out_q     <= out_d;
    chk_idx_q <= chk_idx_d;
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    total_d     = total_q;
    scan_d      = scan_q;
    chk_d       = 1'b0;
    chk_idx_d   = chk_idx_q;
    in_d        = in_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    waddr       = chk_idx_q[IdxW-1:0];
    wdata       = rdata_q;
    raddr       = scan_q[IdxW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        raddr = in_i.read_index[IdxW-1:0];
        if (in_valid_i) begin
          in_d               = in_i;
          res_d              = '0;
          res_d.fill_level   = fill_q;
          res_d.total_frames = total_q;
          unique case (in_i.cmd)
            CMD_RX: begin
              total_d = total_q + 32'd1;
              scan_d  = '0;
              state_d = S_SEARCH;
            end
            CMD_READ: begin
              res_d.entry_index = in_i.read_index;
              if (in_i.read_index < fill_q) begin
                state_d = S_READ;
              end else begin
                res_d.status = ST_BAD_IDX;
                state_d      = S_DONE;
              end
            end
            CMD_CLEAR: begin
              fill_d             = '0;
              total_d            = '0;
              res_d.status       = ST_CLEARED;
              res_d.fill_level   = '0;
              res_d.total_frames = '0;
              state_d            = S_DONE;
            end
            default: ;
          endcase
        end
      end

      S_SEARCH: begin
        res_d.total_frames = total_q;
        if (chk_q && rdata_q.id == in_q.frame_id) begin
          // hit: overwrite the entry just compared
          wdata.id          = rdata_q.id;
          wdata.len         = in_q.frame_len;
          wdata.data        = in_q.frame_data;
          wdata.count       = rdata_q.count + 32'd1;
          we                = 1'b1;
          waddr             = chk_idx_q[IdxW-1:0];
          res_d.status      = ST_UPDATED;
          res_d.entry_index = chk_idx_q;
          res_d.entry_id    = wdata.id;
          res_d.entry_len   = wdata.len;
          res_d.entry_data  = wdata.data;
          res_d.entry_count = wdata.count;
          res_d.fill_level  = fill_q;
          state_d           = S_DONE;
        end else if (scan_q < fill_q) begin
          chk_d     = 1'b1;
          chk_idx_d = scan_q;
          scan_d    = scan_q + 8'd1;
        end else if (!chk_q) begin
          if (fill_q < FillMax) begin
            wdata.id          = in_q.frame_id;
            wdata.len         = in_q.frame_len;
            wdata.data        = in_q.frame_data;
            wdata.count       = 32'd1;
            we                = 1'b1;
            waddr             = fill_q[IdxW-1:0];
            fill_d            = fill_q + 8'd1;
            res_d.status      = ST_INSERTED;
            res_d.entry_index = fill_q;
            res_d.entry_id    = wdata.id;
            res_d.entry_len   = wdata.len;
            res_d.entry_data  = wdata.data;
            res_d.entry_count = wdata.count;
            res_d.fill_level  = fill_q + 8'd1;
          end else begin
            res_d             = '0;
            res_d.status      = ST_DROPPED;
            res_d.fill_level  = fill_q;
            res_d.total_frames = total_q;
          end
          state_d = S_DONE;
        end
      end

      S_READ: begin
        res_d.status      = ST_READ_OK;
        res_d.entry_id    = rdata_q.id;
        res_d.entry_len   = rdata_q.len;
        res_d.entry_data  = rdata_q.data;
        res_d.entry_count = rdata_q.count;
        state_d           = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cimt_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int ITEM_TARGET = 1100;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 400;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall_o;
  cimt_in_t  in_item = '0;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  cimt_out_t out_o;

  can_id_message_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_i       (in_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_o      (out_o)
  );

  cimt_in_t    pending_items[$];
  cimt_out_t   expected_results[$];
  cimt_entry_t entry_mem[TABLE_DEPTH];
  int          fill_cnt = 0;
  logic [31:0] frames_seen = '0;
  int          items_made = 0;
  int          fail_count = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          next_hold_at = 150;
  logic        quiet_tail = 1'b0;
  cimt_out_t   want;
  logic [28:0] id_pool[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // table predictor, one call per accepted item
  task automatic predict_item(input cimt_in_t it);
    cimt_out_t res;
    int hit;
    int shown;
    res = '0;
    hit = -1;
    shown = -1;
    case (it.cmd)
      CMD_RX: begin
        frames_seen = frames_seen + 32'd1;
        for (int i = 0; i < fill_cnt; i++) begin
          if (hit < 0 && entry_mem[i].id == it.frame_id) hit = i;
        end
        if (hit >= 0) begin
          entry_mem[hit].count = entry_mem[hit].count + 32'd1;
          res.status = ST_UPDATED;
        end else if (fill_cnt < TABLE_DEPTH) begin
          hit = fill_cnt;
          fill_cnt++;
          entry_mem[hit].id = it.frame_id;
          entry_mem[hit].count = 32'd1;
          res.status = ST_INSERTED;
        end else begin
          res.status = ST_DROPPED;
        end
        if (hit >= 0) begin
          entry_mem[hit].len = it.frame_len;
          entry_mem[hit].data = it.frame_data;
        end
        shown = hit;
      end
      CMD_READ: begin
        if (int'(it.read_index) < fill_cnt) begin
          res.status = ST_READ_OK;
          shown = int'(it.read_index);
        end else begin
          res.status = ST_BAD_IDX;
          res.entry_index = it.read_index;
        end
      end
      CMD_CLEAR: begin
        fill_cnt = 0;
        frames_seen = '0;
        res.status = ST_CLEARED;
      end
      default: return;
    endcase
    if (shown >= 0) begin
      res.entry_index = 8'(shown);
      res.entry_id = entry_mem[shown].id;
      res.entry_len = entry_mem[shown].len;
      res.entry_data = entry_mem[shown].data;
      res.entry_count = entry_mem[shown].count;
    end
    res.fill_level = 8'(fill_cnt);
    res.total_frames = frames_seen;
    expected_results.push_back(res);
  endtask

  function automatic cimt_in_t noise_item();
    cimt_in_t it;
    it.cmd = cmd_t'($urandom);
    it.frame_id = 29'($urandom);
    it.frame_len = 4'($urandom);
    it.frame_data = {$urandom, $urandom};
    it.read_index = 8'($urandom);
    return it;
  endfunction

  task automatic queue_frame(input logic [28:0] id, input logic [3:0] len,
                             input logic [63:0] data);
    cimt_in_t it;
    it = noise_item();
    it.cmd = CMD_RX;
    it.frame_id = id;
    it.frame_len = len;
    it.frame_data = data;
    pending_items.push_back(it);
    items_made++;
  endtask

  task automatic queue_read(input logic [7:0] idx);
    cimt_in_t it;
    it = noise_item();
    it.cmd = CMD_READ;
    it.read_index = idx;
    pending_items.push_back(it);
    items_made++;
  endtask

  task automatic queue_clear();
    cimt_in_t it;
    it = noise_item();
    it.cmd = CMD_CLEAR;
    pending_items.push_back(it);
    items_made++;
  endtask

  // reserved command, no result expected
  task automatic queue_reserved();
    cimt_in_t it;
    it = noise_item();
    it.cmd = CMD_RSVD;
    pending_items.push_back(it);
  endtask

  function automatic logic [3:0] pick_len();
    return ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
  endfunction

  task automatic build_stimulus();
    int n;
    int pool_size;
    int seq;
    int roll;
    bit fill_phase;
    bit first;
    logic [28:0] id;
    // directed part
    queue_frame(29'd0, 4'd0, 64'd0);
    queue_frame(29'h1fffffff, 4'd15, '1);
    queue_frame(29'd0, 4'd8, 64'h0123_4567_89ab_cdef);
    queue_read(8'd0);
    queue_read(8'd1);
    queue_read(8'd2);
    queue_read(8'd255);
    queue_reserved();
    queue_frame(29'h7ff, 4'd9, {$urandom, $urandom});
    queue_read(8'd2);
    queue_clear();
    queue_read(8'd0);
    queue_frame(29'h1fffffff, 4'd4, {$urandom, $urandom});
    queue_read(8'd0);
    queue_read(8'd1);
    // random part: sequences over an identifier pool
    first = 1'b1;
    while (items_made < ITEM_TARGET) begin
      fill_phase = first || ($urandom_range(0, 2) == 0);
      first = 1'b0;
      if (fill_phase) begin
        pool_size = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 50);
        n = pool_size + $urandom_range(20, 60);
      end else begin
        pool_size = $urandom_range(1, 20);
        n = $urandom_range(20, 80);
      end
      id_pool.delete();
      for (int j = 0; j < pool_size; j++) begin
        if ($urandom_range(0, 3) == 0) id_pool.push_back(29'($urandom_range(0, 2047)));
        else id_pool.push_back(29'($urandom));
      end
      if ($urandom_range(0, 1) == 0) queue_clear();
      seq = 0;
      for (int k = 0; k < n && items_made < ITEM_TARGET; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
          if (fill_phase && seq < pool_size) begin
            id = id_pool[seq];
            seq++;
          end else begin
            id = id_pool[$urandom_range(0, pool_size - 1)];
          end
          queue_frame(id, pick_len(), {$urandom, $urandom});
        end else if (roll < 84) begin
          queue_frame(29'($urandom), pick_len(), {$urandom, $urandom});
        end else if (roll < 94) begin
          queue_read(8'($urandom_range(0, fill_phase ? TABLE_DEPTH + 4 : pool_size + 2)));
        end else if (roll < 97) begin
          queue_read(8'($urandom));
        end else if (roll < 98) begin
          queue_clear();
        end else begin
          queue_reserved();
        end
      end
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
      gap_left <= 0;
      quiet_tail <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) predict_item(in_item);
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!quiet_tail && cycle_count[10:9] != 2'b00 && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      quiet_tail <= pending_items.size() < 120;
    end
  end

  // receiver stall, with long hold-offs to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      next_hold_at <= 150;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (next_hold_at != 0 && results_seen >= next_hold_at) begin
      hold_left <= LONG_HOLD;
      next_hold_at <= (next_hold_at == 150) ? 600 : 0;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet_tail && cycle_count[11:10] != 2'b00 && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no item pending, status %0d", out_o.status);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 64'(want.status), 64'(out_o.status));
        check_field("entry_index", 64'(want.entry_index), 64'(out_o.entry_index));
        check_field("entry_id", 64'(want.entry_id), 64'(out_o.entry_id));
        check_field("entry_len", 64'(want.entry_len), 64'(out_o.entry_len));
        check_field("entry_data", want.entry_data, out_o.entry_data);
        check_field("entry_count", 64'(want.entry_count), 64'(out_o.entry_count));
        check_field("fill_level", 64'(want.fill_level), 64'(out_o.fill_level));
        check_field("total_frames", 64'(want.total_frames), 64'(out_o.total_frames));
      end
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
